@@ design/disk_request_ring_queue_top_macros.svh @@
// Assertion macros for the request ring queue.
`ifndef DISK_REQUEST_RING_QUEUE_TOP_MACROS_SVH
`define DISK_REQUEST_RING_QUEUE_TOP_MACROS_SVH

// Condition a implies condition b in the same cycle.
`define DRRQ_ASSERT_NOW(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("Request queue check failed.");

// Condition a implies condition b in the next cycle.
`define DRRQ_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("Request queue check failed.");

`endif

@@ design/drrq_pkg.sv @@
// Package with the types and constants of the request ring queue.
`timescale 1ns / 1ps

package drrq_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;

  localparam int LBA_W    = 48;
  localparam int COUNT_W  = 16;
  localparam int BUF_W    = 64;
  localparam int STATUS_W = 8;
  localparam int SLOT_W   = 4;
  localparam int CAP_W    = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [1:0] {
    FUNC_SUBMIT   = 2'd0,
    FUNC_FETCH    = 2'd1,
    FUNC_COMPLETE = 2'd2,
    FUNC_RELEASE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_FULL       = 2'd1,
    ERR_EMPTY      = 2'd2,
    ERR_WRONG_SLOT = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    PH_FREE     = 2'd0,
    PH_QUEUED   = 2'd1,
    PH_INFLIGHT = 2'd2,
    PH_DONE     = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SUBMIT,
    S_FETCH,
    S_FETCH_DATA,
    S_COMPLETE,
    S_REL_CHECK,
    S_REL_WALK,
    S_REL_RECLAIM
  } state_t;

  typedef struct packed {
    logic [LBA_W-1:0]   lba;
    logic [COUNT_W-1:0] sector_count;
    logic               is_write;
    logic [BUF_W-1:0]   buffer_addr;
  } entry_t;

  typedef struct packed {
    logic   mem_we;
    logic   stat_we;
    logic   ph_we;
    phase_t ph_val;
    logic   wp_step;
    logic   fp_step;
    logic   rp_step;
    logic   pend_inc;
    logic   pend_dec;
    logic   done_inc;
    logic   done_dec;
    logic   walk_load;
    logic   walk_step;
    logic   report;
    err_t   rep_err;
  } ctl_t;

endpackage

@@ design/disk_request_ring_queue_top.sv @@
// Top level of the request ring queue: sequencer, slot memories and pointers.
`timescale 1ns / 1ps
`include "disk_request_ring_queue_top_macros.svh"

// The host issues one command at a time on start/func and the payload ports.
// A command is taken at a clock edge where start is high and busy is low.
// Each command gives one result, shown for exactly one cycle while done is
// high; the receiver cannot stall, so the result must be taken in that cycle.
// Submit and complete report from their own state, from which done is
// registered; a successful fetch also passes through S_FETCH_DATA for the
// registered read of the slot memory. Release checks the named slot, walks
// the done slots from the release pointer to it and reclaims released slots,
// one slot per cycle through the shared pointer stepper. Busy falls in the
// cycle in which done is high, so the next command can be taken in it.
// The capacity register is written on its own channel (cfg_valid, cfg_ready,
// cfg_data). The user must write it only while no command is in progress;
// the block does not enforce this. cfg_ready is always high. Reset clears
// all pointers and counts, marks every slot free and sets the capacity to 16.
// Slot contents are not cleared.
module disk_request_ring_queue_top #(
  parameter int QUEUE_DEPTH = drrq_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     func,
  input  logic [drrq_pkg::LBA_W-1:0]     lba,
  input  logic [drrq_pkg::COUNT_W-1:0]   sector_count,
  input  logic                           is_write,
  input  logic [drrq_pkg::BUF_W-1:0]     buffer_addr,
  input  logic [drrq_pkg::STATUS_W-1:0]  completion_status,
  input  logic [drrq_pkg::SLOT_W-1:0]    slot,
  output logic                           done,
  output logic                           ok,
  output drrq_pkg::err_t                 error_code,
  output logic [drrq_pkg::SLOT_W-1:0]    slot_index,
  output logic [drrq_pkg::LBA_W-1:0]     out_lba,
  output logic [drrq_pkg::COUNT_W-1:0]   out_sector_count,
  output logic                           out_is_write,
  output logic [drrq_pkg::BUF_W-1:0]     out_buffer_addr,
  output logic [drrq_pkg::STATUS_W-1:0]  out_status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [drrq_pkg::CAP_W-1:0]     cfg_data
);

  import drrq_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  state_t state;
  state_t state_next;
  ctl_t   ctl;

  logic [CAP_W-1:0]    capacity;
  logic [CNT_W-1:0]    eff_cap;
  logic [PTR_W-1:0]    write_ptr;
  logic [PTR_W-1:0]    fetch_ptr;
  logic [PTR_W-1:0]    release_ptr;
  logic [CNT_W-1:0]    pend_cnt;
  logic [CNT_W-1:0]    done_cnt;
  logic [CNT_W:0]      occupancy;
  phase_t              phase [QUEUE_DEPTH];
  logic [PTR_W-1:0]    phase_addr;
  phase_t              ph_rd;

  entry_t              req_entry;
  logic [STATUS_W-1:0] req_status;
  logic [SLOT_W-1:0]   req_slot;
  logic [PTR_W-1:0]    slot_idx;
  logic                slot_in_range;

  entry_t              req_mem [QUEUE_DEPTH];
  logic [STATUS_W-1:0] stat_mem [QUEUE_DEPTH];
  entry_t              rd_entry;
  logic [STATUS_W-1:0] rd_status;

  logic [PTR_W-1:0]    walk_pos;
  logic [CNT_W-1:0]    walk_rem;
  logic [PTR_W-1:0]    step_in;
  logic [PTR_W-1:0]    step_out;

  logic full;
  logic fetch_good;
  logic cpl_good;
  logic rel_good;
  logic walk_hit;
  logic walk_last;
  logic reclaim_go;

  function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] cap);
    logic [PTR_W:0] n;
    n = {1'b0, p} + (PTR_W + 1)'(1);
    if (n >= (PTR_W + 1)'(cap)) begin
      return '0;
    end
    return n[PTR_W-1:0];
  endfunction

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CNT_W'(1);
    end else if (int'(capacity) > QUEUE_DEPTH) begin
      eff_cap = CNT_W'(QUEUE_DEPTH);
    end else begin
      eff_cap = CNT_W'(capacity);
    end
  end

  assign occupancy     = {1'b0, pend_cnt} + {1'b0, done_cnt};
  assign full          = occupancy >= {1'b0, eff_cap};
  assign slot_idx      = PTR_W'(req_slot);
  assign slot_in_range = int'(req_slot) < QUEUE_DEPTH;

  always_comb begin
    unique case (state)
      S_SUBMIT:                    phase_addr = write_ptr;
      S_REL_CHECK, S_REL_WALK:     phase_addr = slot_idx;
      S_REL_RECLAIM:               phase_addr = release_ptr;
      default:                     phase_addr = fetch_ptr;
    endcase
  end

  assign ph_rd = phase[phase_addr];

  // One pointer stepper serves every pointer update and the window walk.
  always_comb begin
    unique case (state)
      S_SUBMIT:      step_in = write_ptr;
      S_REL_WALK:    step_in = walk_pos;
      S_REL_RECLAIM: step_in = release_ptr;
      default:       step_in = fetch_ptr;
    endcase
  end

  assign step_out = step_ptr(step_in, eff_cap);

  assign fetch_good = (pend_cnt != '0) && (ph_rd == PH_QUEUED);
  assign cpl_good   = (pend_cnt != '0) && (ph_rd == PH_INFLIGHT);
  assign rel_good   = slot_in_range && (done_cnt != '0) && (ph_rd == PH_DONE);
  assign walk_hit   = (walk_pos == slot_idx);
  assign walk_last  = (walk_rem == CNT_W'(1));
  assign reclaim_go = (done_cnt != '0) && (ph_rd == PH_FREE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (func_t'(func))
            FUNC_SUBMIT:   state_next = S_SUBMIT;
            FUNC_FETCH:    state_next = S_FETCH;
            FUNC_COMPLETE: state_next = S_COMPLETE;
            FUNC_RELEASE:  state_next = S_REL_CHECK;
            default:       state_next = S_IDLE;
          endcase
        end
      end
      S_SUBMIT:     state_next = S_IDLE;
      S_FETCH:      state_next = fetch_good ? S_FETCH_DATA : S_IDLE;
      S_FETCH_DATA: state_next = S_IDLE;
      S_COMPLETE:   state_next = S_IDLE;
      S_REL_CHECK:  state_next = rel_good ? S_REL_WALK : S_IDLE;
      S_REL_WALK: begin
        if (walk_hit) begin
          state_next = S_REL_RECLAIM;
        end else if (walk_last) begin
          state_next = S_IDLE;
        end
      end
      S_REL_RECLAIM: begin
        if (!reclaim_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.ph_val  = PH_FREE;
    ctl.rep_err = ERR_NONE;
    unique case (state)
      S_SUBMIT: begin
        ctl.report = 1'b1;
        if (full) begin
          ctl.rep_err = ERR_FULL;
        end else begin
          ctl.mem_we   = 1'b1;
          ctl.ph_we    = 1'b1;
          ctl.ph_val   = PH_QUEUED;
          ctl.wp_step  = 1'b1;
          ctl.pend_inc = 1'b1;
        end
      end
      S_FETCH: begin
        if (pend_cnt == '0) begin
          ctl.report  = 1'b1;
          ctl.rep_err = ERR_EMPTY;
        end else if (!fetch_good) begin
          ctl.report  = 1'b1;
          ctl.rep_err = ERR_WRONG_SLOT;
        end else begin
          ctl.ph_we  = 1'b1;
          ctl.ph_val = PH_INFLIGHT;
        end
      end
      S_FETCH_DATA: begin
        ctl.report = 1'b1;
      end
      S_COMPLETE: begin
        ctl.report = 1'b1;
        if (pend_cnt == '0) begin
          ctl.rep_err = ERR_EMPTY;
        end else if (!cpl_good) begin
          ctl.rep_err = ERR_WRONG_SLOT;
        end else begin
          ctl.stat_we  = 1'b1;
          ctl.ph_we    = 1'b1;
          ctl.ph_val   = PH_DONE;
          ctl.fp_step  = 1'b1;
          ctl.pend_dec = 1'b1;
          ctl.done_inc = 1'b1;
        end
      end
      S_REL_CHECK: begin
        if (rel_good) begin
          ctl.walk_load = 1'b1;
        end else begin
          ctl.report  = 1'b1;
          ctl.rep_err = ERR_WRONG_SLOT;
        end
      end
      S_REL_WALK: begin
        if (walk_hit) begin
          ctl.ph_we  = 1'b1;
          ctl.ph_val = PH_FREE;
        end else if (walk_last) begin
          ctl.report  = 1'b1;
          ctl.rep_err = ERR_WRONG_SLOT;
        end else begin
          ctl.walk_step = 1'b1;
        end
      end
      S_REL_RECLAIM: begin
        if (reclaim_go) begin
          ctl.rp_step  = 1'b1;
          ctl.done_dec = 1'b1;
        end else begin
          ctl.report = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      capacity    <= CAP_RESET;
      write_ptr   <= '0;
      fetch_ptr   <= '0;
      release_ptr <= '0;
      pend_cnt    <= '0;
      done_cnt    <= '0;
      done        <= 1'b0;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        phase[i] <= PH_FREE;
      end
    end else begin
      state <= state_next;
      done  <= ctl.report;
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (ctl.ph_we) begin
        phase[phase_addr] <= ctl.ph_val;
      end
      if (ctl.wp_step) begin
        write_ptr <= step_out;
      end
      if (ctl.fp_step) begin
        fetch_ptr <= step_out;
      end
      if (ctl.rp_step) begin
        release_ptr <= step_out;
      end
      if (ctl.pend_inc) begin
        pend_cnt <= pend_cnt + CNT_W'(1);
      end else if (ctl.pend_dec) begin
        pend_cnt <= pend_cnt - CNT_W'(1);
      end
      if (ctl.done_inc) begin
        done_cnt <= done_cnt + CNT_W'(1);
      end else if (ctl.done_dec) begin
        done_cnt <= done_cnt - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      req_entry.lba          <= lba;
      req_entry.sector_count <= sector_count;
      req_entry.is_write     <= is_write;
      req_entry.buffer_addr  <= buffer_addr;
      req_status             <= completion_status;
      req_slot               <= slot;
    end
    if (ctl.walk_load) begin
      walk_pos <= release_ptr;
      walk_rem <= done_cnt;
    end else if (ctl.walk_step) begin
      walk_pos <= step_out;
      walk_rem <= walk_rem - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mem_we) begin
      req_mem[write_ptr] <= req_entry;
    end
    rd_entry <= req_mem[fetch_ptr];
  end

  always_ff @(posedge clk) begin
    if (ctl.stat_we) begin
      stat_mem[fetch_ptr] <= req_status;
    end
    rd_status <= stat_mem[slot_idx];
  end

  always_ff @(posedge clk) begin
    if (ctl.report) begin
      ok               <= (ctl.rep_err == ERR_NONE);
      error_code       <= ctl.rep_err;
      slot_index       <= '0;
      out_lba          <= '0;
      out_sector_count <= '0;
      out_is_write     <= 1'b0;
      out_buffer_addr  <= '0;
      out_status       <= '0;
      if (ctl.rep_err == ERR_NONE) begin
        unique case (state)
          S_SUBMIT: begin
            slot_index <= SLOT_W'(write_ptr);
          end
          S_FETCH_DATA: begin
            slot_index       <= SLOT_W'(fetch_ptr);
            out_lba          <= rd_entry.lba;
            out_sector_count <= rd_entry.sector_count;
            out_is_write     <= rd_entry.is_write;
            out_buffer_addr  <= rd_entry.buffer_addr;
          end
          S_COMPLETE: begin
            slot_index <= SLOT_W'(fetch_ptr);
          end
          S_REL_RECLAIM: begin
            slot_index <= req_slot;
            out_status <= rd_status;
          end
          default: begin
          end
        endcase
      end
    end
  end

  `DRRQ_ASSERT_NOW(a_done_when_idle, clk, rst, done, !busy)
  `DRRQ_ASSERT_NOW(a_occupancy_bound, clk, rst, 1'b1, occupancy <= (CNT_W + 1)'(QUEUE_DEPTH))
  `DRRQ_ASSERT_NEXT(a_accept_sets_busy, clk, rst, start && !busy, busy)

endmodule

@@ bench/disk_request_ring_queue_top_test.sv @@
// Self-checking testbench for the request ring queue: directed and random commands.
`timescale 1ns / 1ps

module disk_request_ring_queue_top_test;
  import drrq_pkg::*;

  localparam int DEPTH       = DEFAULT_QUEUE_DEPTH;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    func_t                op;
    logic [LBA_W-1:0]     lba;
    logic [COUNT_W-1:0]   count;
    logic                 wr;
    logic [BUF_W-1:0]     buf_addr;
    logic [STATUS_W-1:0]  status;
    logic [SLOT_W-1:0]    slot;
  } ring_cmd_t;

  typedef struct packed {
    logic                 ok;
    err_t                 err;
    logic [SLOT_W-1:0]    slot;
    logic [LBA_W-1:0]     lba;
    logic [COUNT_W-1:0]   count;
    logic                 wr;
    logic [BUF_W-1:0]     buf_addr;
    logic [STATUS_W-1:0]  status;
  } ring_reply_t;

  class request_ring_scoreboard;
    logic [LBA_W-1:0]    slot_lba    [DEPTH];
    logic [COUNT_W-1:0]  slot_count  [DEPTH];
    logic                slot_wr     [DEPTH];
    logic [BUF_W-1:0]    slot_buf    [DEPTH];
    logic [STATUS_W-1:0] slot_status [DEPTH];
    phase_t              slot_phase  [DEPTH];
    int                  wp, fp, rp, n_pending, n_done;
    logic [CAP_W-1:0]    cap_reg;
    ring_reply_t         replies_due [$];
    int                  mismatches;
    int                  replies_checked;

    function new();
      for (int i = 0; i < DEPTH; i++) begin
        slot_phase[i] = PH_FREE;
      end
      wp = 0;
      fp = 0;
      rp = 0;
      n_pending = 0;
      n_done = 0;
      cap_reg = CAP_RESET;
      mismatches = 0;
      replies_checked = 0;
    endfunction

    function int capacity_now();
      int c;
      c = cap_reg;
      if (c < 1) c = 1;
      if (c > DEPTH) c = DEPTH;
      return c;
    endfunction

    function int advance(int p);
      int n;
      n = p + 1;
      if (n >= capacity_now()) n = 0;
      return n;
    endfunction

    function void note_command(ring_cmd_t c);
      ring_reply_t r;
      int s;
      int pos;
      bit in_window;
      r = '0;
      r.err = ERR_NONE;
      case (c.op)
        FUNC_SUBMIT: begin
          if (n_pending + n_done >= capacity_now()) begin
            r.err = ERR_FULL;
          end else begin
            slot_lba[wp] = c.lba;
            slot_count[wp] = c.count;
            slot_wr[wp] = c.wr;
            slot_buf[wp] = c.buf_addr;
            slot_phase[wp] = PH_QUEUED;
            r.ok = 1'b1;
            r.slot = SLOT_W'(wp);
            wp = advance(wp);
            n_pending++;
          end
        end
        FUNC_FETCH: begin
          if (n_pending == 0) begin
            r.err = ERR_EMPTY;
          end else if (slot_phase[fp] != PH_QUEUED) begin
            r.err = ERR_WRONG_SLOT;
          end else begin
            slot_phase[fp] = PH_INFLIGHT;
            r.ok = 1'b1;
            r.slot = SLOT_W'(fp);
            r.lba = slot_lba[fp];
            r.count = slot_count[fp];
            r.wr = slot_wr[fp];
            r.buf_addr = slot_buf[fp];
          end
        end
        FUNC_COMPLETE: begin
          if (n_pending == 0) begin
            r.err = ERR_EMPTY;
          end else if (slot_phase[fp] != PH_INFLIGHT) begin
            r.err = ERR_WRONG_SLOT;
          end else begin
            slot_status[fp] = c.status;
            slot_phase[fp] = PH_DONE;
            r.ok = 1'b1;
            r.slot = SLOT_W'(fp);
            fp = advance(fp);
            n_pending--;
            n_done++;
          end
        end
        default: begin
          s = c.slot;
          in_window = 1'b0;
          if (n_done != 0 && slot_phase[s] == PH_DONE) begin
            pos = rp;
            for (int rem = n_done; rem > 0; rem--) begin
              if (pos == s) begin
                in_window = 1'b1;
                break;
              end
              pos = advance(pos);
            end
          end
          if (!in_window) begin
            r.err = ERR_WRONG_SLOT;
          end else begin
            slot_phase[s] = PH_FREE;
            while (n_done > 0 && slot_phase[rp] == PH_FREE) begin
              rp = advance(rp);
              n_done--;
            end
            r.ok = 1'b1;
            r.slot = c.slot;
            r.status = slot_status[s];
          end
        end
      endcase
      replies_due.push_back(r);
    endfunction

    function void compare_field(string name, logic [BUF_W-1:0] exp_v, logic [BUF_W-1:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
        mismatches++;
      end
    endfunction

    function void check_reply(ring_reply_t a);
      ring_reply_t e;
      if (replies_due.size() == 0) begin
        $display("%0t: result with no command outstanding, expected none, actual %h", $time, a);
        mismatches++;
        return;
      end
      e = replies_due.pop_front();
      replies_checked++;
      compare_field("ok", e.ok, a.ok);
      compare_field("error_code", e.err, a.err);
      compare_field("slot_index", e.slot, a.slot);
      compare_field("out_lba", e.lba, a.lba);
      compare_field("out_sector_count", e.count, a.count);
      compare_field("out_is_write", e.wr, a.wr);
      compare_field("out_buffer_addr", e.buf_addr, a.buf_addr);
      compare_field("out_status", e.status, a.status);
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [1:0]           func;
  logic [LBA_W-1:0]     lba;
  logic [COUNT_W-1:0]   sector_count;
  logic                 is_write;
  logic [BUF_W-1:0]     buffer_addr;
  logic [STATUS_W-1:0]  completion_status;
  logic [SLOT_W-1:0]    slot;
  logic                 done;
  logic                 ok;
  err_t                 error_code;
  logic [SLOT_W-1:0]    slot_index;
  logic [LBA_W-1:0]     out_lba;
  logic [COUNT_W-1:0]   out_sector_count;
  logic                 out_is_write;
  logic [BUF_W-1:0]     out_buffer_addr;
  logic [STATUS_W-1:0]  out_status;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CAP_W-1:0]     cfg_data;

  request_ring_scoreboard sb = new();
  int quiet_cycles = 0;
  int op_seen [4];
  int cap_writes = 0;

  disk_request_ring_queue_top #(.QUEUE_DEPTH(DEPTH)) u_top (
    .clk               (clk),
    .rst               (rst),
    .start             (start),
    .busy              (busy),
    .func              (func),
    .lba               (lba),
    .sector_count      (sector_count),
    .is_write          (is_write),
    .buffer_addr       (buffer_addr),
    .completion_status (completion_status),
    .slot              (slot),
    .done              (done),
    .ok                (ok),
    .error_code        (error_code),
    .slot_index        (slot_index),
    .out_lba           (out_lba),
    .out_sector_count  (out_sector_count),
    .out_is_write      (out_is_write),
    .out_buffer_addr   (out_buffer_addr),
    .out_status        (out_status),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    ring_reply_t seen;
    if (!rst && done) begin
      seen.ok = ok;
      seen.err = error_code;
      seen.slot = slot_index;
      seen.lba = out_lba;
      seen.count = out_sector_count;
      seen.wr = out_is_write;
      seen.buf_addr = out_buffer_addr;
      seen.status = out_status;
      sb.check_reply(seen);
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic ring_cmd_t random_command(func_t op);
    ring_cmd_t c;
    c.op = op;
    c.lba = LBA_W'({$urandom, $urandom});
    c.count = COUNT_W'($urandom);
    c.wr = 1'($urandom);
    c.buf_addr = {$urandom, $urandom};
    c.status = STATUS_W'($urandom);
    c.slot = SLOT_W'($urandom);
    return c;
  endfunction

  // Mostly legal next steps for the current ring state, with some noise mixed in.
  function automatic ring_cmd_t pick_command();
    ring_cmd_t c;
    func_t options [$];
    int done_slots [$];
    c = random_command(func_t'($urandom_range(0, 3)));
    if ($urandom_range(0, 99) < 12) return c;
    if (sb.n_pending + sb.n_done < sb.capacity_now()) begin
      options.push_back(FUNC_SUBMIT);
      options.push_back(FUNC_SUBMIT);
    end
    if (sb.n_pending > 0 && sb.slot_phase[sb.fp] == PH_QUEUED) options.push_back(FUNC_FETCH);
    if (sb.n_pending > 0 && sb.slot_phase[sb.fp] == PH_INFLIGHT) options.push_back(FUNC_COMPLETE);
    for (int i = 0; i < DEPTH; i++) begin
      if (sb.slot_phase[i] == PH_DONE) done_slots.push_back(i);
    end
    if (done_slots.size() > 0) options.push_back(FUNC_RELEASE);
    if (options.size() == 0) return c;
    c.op = options[$urandom_range(0, options.size() - 1)];
    if (c.op == FUNC_RELEASE) begin
      c.slot = SLOT_W'(done_slots[$urandom_range(0, done_slots.size() - 1)]);
    end
    return c;
  endfunction

  task automatic issue(input ring_cmd_t c);
    start <= 1'b1;
    func <= c.op;
    lba <= c.lba;
    sector_count <= c.count;
    is_write <= c.wr;
    buffer_addr <= c.buf_addr;
    completion_status <= c.status;
    slot <= c.slot;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(c);
    op_seen[c.op]++;
  endtask

  task automatic idle_for(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.replies_due.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.cap_reg = value;
    cfg_valid <= 1'b0;
    cap_writes++;
  endtask

  task automatic issue_op(input func_t op);
    issue(random_command(op));
  endtask

  task automatic issue_release(input logic [SLOT_W-1:0] s);
    ring_cmd_t c;
    c = random_command(FUNC_RELEASE);
    c.slot = s;
    issue(c);
  endtask

  task automatic issue_complete(input logic [STATUS_W-1:0] st);
    ring_cmd_t c;
    c = random_command(FUNC_COMPLETE);
    c.status = st;
    issue(c);
  endtask

  task automatic random_phase(input int n_items);
    int burst;
    burst = $urandom_range(1, 24);
    for (int k = 0; k < n_items; k++) begin
      issue(pick_command());
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if ($urandom_range(0, 3) != 0) idle_for($urandom_range(1, 8));
      end
      if ($urandom_range(0, 79) == 0) hold_until_drained();
    end
  endtask

  initial begin
    ring_cmd_t c;
    logic [CAP_W-1:0] caps [8];
    rst = 1'b1;
    start = 1'b0;
    func = FUNC_SUBMIT;
    lba = '0;
    sector_count = '0;
    is_write = 1'b0;
    buffer_addr = '0;
    completion_status = '0;
    slot = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    set_capacity(CAP_W'(16));

    // Empty-queue errors, then two requests at the field extremes.
    issue_op(FUNC_FETCH);
    issue_op(FUNC_COMPLETE);
    issue_release(SLOT_W'(15));
    c = random_command(FUNC_SUBMIT);
    c.lba = '1;
    c.count = '1;
    c.wr = 1'b1;
    c.buf_addr = '1;
    issue(c);
    c.lba = '0;
    c.count = '0;
    c.wr = 1'b0;
    c.buf_addr = '0;
    issue(c);
    issue_op(FUNC_FETCH);
    issue_op(FUNC_FETCH);
    issue_release(SLOT_W'(0));
    issue_complete(8'hFF);
    issue_op(FUNC_COMPLETE);
    issue_op(FUNC_FETCH);
    issue_complete(8'h00);
    // Out-of-order release, a repeated release, then the reclaim of both slots.
    issue_release(SLOT_W'(1));
    issue_release(SLOT_W'(1));
    issue_release(SLOT_W'(0));

    // A single slot in use, with the pointers kept from the wider ring.
    hold_until_drained();
    set_capacity(CAP_W'(1));
    issue_op(FUNC_SUBMIT);
    issue_op(FUNC_SUBMIT);
    issue_op(FUNC_FETCH);
    issue_op(FUNC_COMPLETE);
    issue_op(FUNC_SUBMIT);
    issue_release(SLOT_W'(2));

    hold_until_drained();
    set_capacity(CAP_W'(0));
    issue_op(FUNC_SUBMIT);
    issue_op(FUNC_SUBMIT);

    caps[0] = CAP_W'(31);
    caps[1] = CAP_W'(16);
    caps[2] = CAP_W'(2);
    caps[3] = CAP_W'($urandom_range(3, 15));
    caps[4] = CAP_W'(0);
    caps[5] = CAP_W'(17);
    caps[6] = CAP_W'($urandom_range(1, 15));
    caps[7] = CAP_W'(16);
    for (int p = 0; p < 8; p++) begin
      hold_until_drained();
      set_capacity(caps[p]);
      random_phase(185);
    end

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d commands: %0d submit, %0d fetch, %0d complete, %0d release.",
             op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3],
             op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    $display("Checked %0d results across %0d capacity writes, %0d mismatches.",
             sb.replies_checked, cap_writes, sb.mismatches);
    if (sb.mismatches == 0 && sb.replies_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ disk_request_ring_queue_top.f @@
+incdir+design
design/drrq_pkg.sv
design/disk_request_ring_queue_top.sv
bench/disk_request_ring_queue_top_test.sv
